[design/mk2_pkg.sv]
// ----------------------------------------------------------------------------
// mk2_pkg
// Shared types, constants and one-step update functions for the MICKEY 2.0
// keystream word generator.
// ----------------------------------------------------------------------------
package mk2_pkg;

   localparam int REG_W      = 100;
   localparam int HALF_W     = 80;
   localparam int WORD_W     = 32;
   localparam int CNT_W      = 7;
   localparam int IVLEN_W    = 7;
   localparam int NBITS_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [IVLEN_W-1:0] IV_BITS_MAX   = 7'd80;
   localparam logic [NBITS_W-1:0] WORD_BITS_MAX = 6'd32;
   localparam logic [CNT_W-1:0]   KEY_LAST      = 7'd79;
   localparam logic [CNT_W-1:0]   PRE_LAST      = 7'd99;

   localparam logic [CSR_IDX_W-1:0] CSR_IV_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_BITS  = 2'd1;

   localparam logic [REG_W-1:0] R_TAPS  = 100'h3_df87818f_b5546660_1279327b;
   localparam logic [REG_W-1:0] S_COMP0 = 100'h6_057ebfea_7942a809_6aa97a30;
   localparam logic [REG_W-1:0] S_COMP1 = 100'h1_91c23dd7_e3a21d63_dd629e9a;
   localparam logic [REG_W-1:0] S_FB0   = 100'h1_9cec5802_af4a9381_9ffa7faf;
   localparam logic [REG_W-1:0] S_FB1   = 100'h8_40fbc52b_4911b063_4c8cb877;
   localparam logic [REG_W-1:0] S_MASK  = 100'h7_ffffffff_ffffffff_fffffffe;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IV,
      ST_KEY,
      ST_PRE,
      ST_GEN,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      IN_ZERO,
      IN_IV,
      IN_KEY
   } in_sel_type;

   typedef struct packed {
      logic       load;
      logic       step;
      in_sel_type in_sel;
      logic       mixing;
      logic       capture;
      logic       finish;
   } mk2_ctrl_type;

   function automatic logic [REG_W-1:0] r_next(logic [REG_W-1:0] r, logic in_bit,
                                               logic ctrl);
      logic             fb;
      logic [REG_W-1:0] t;
      fb = r[REG_W-1] ^ in_bit;
      t  = {r[REG_W-2:0], 1'b0};
      if (ctrl) t = t ^ r;
      if (fb)   t = t ^ R_TAPS;
      return t;
   endfunction

   function automatic logic [REG_W-1:0] s_next(logic [REG_W-1:0] s, logic in_bit,
                                               logic ctrl);
      logic             fb;
      logic [REG_W-1:0] up;
      logic [REG_W-1:0] dn;
      logic [REG_W-1:0] m;
      logic [REG_W-1:0] t;
      fb = s[REG_W-1] ^ in_bit;
      up = {s[REG_W-2:0], 1'b0};
      dn = {1'b0, s[REG_W-1:1]};
      m  = (s ^ S_COMP0) & (dn ^ S_COMP1) & S_MASK;
      t  = up ^ m;
      if (fb) t = t ^ (ctrl ? S_FB1 : S_FB0);
      return t;
   endfunction

endpackage

[design/mk2_core.sv]
// ----------------------------------------------------------------------------
// mk2_core
// R and S registers with the shared single-step update, key and IV shifters
// and the keystream word accumulator.
// ----------------------------------------------------------------------------
module mk2_core import mk2_pkg::*; (
   input  logic                 clock,
   input  mk2_ctrl_type         ctrl,
   input  logic [HALF_W-1:0]    key_bits,
   input  logic [HALF_W-1:0]    iv_bits,
   output logic [WORD_W-1:0]    word
);

   logic [REG_W-1:0]  r_ff,   r_in;
   logic [REG_W-1:0]  s_ff,   s_in;
   logic [HALF_W-1:0] key_ff, key_in;
   logic [HALF_W-1:0] iv_ff,  iv_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] pos_ff, pos_in;

   logic in_bit;
   logic ctrl_r;
   logic ctrl_s;
   logic z_bit;

   always_comb begin
      unique case (ctrl.in_sel)
         IN_IV:   in_bit = iv_ff[HALF_W-1];
         IN_KEY:  in_bit = key_ff[HALF_W-1];
         default: in_bit = 1'b0;
      endcase
   end

   assign ctrl_r = s_ff[34] ^ r_ff[67];
   assign ctrl_s = s_ff[67] ^ r_ff[33];
   assign z_bit  = r_ff[0] ^ s_ff[0];

   always_comb begin
      r_in   = r_ff;
      s_in   = s_ff;
      key_in = key_ff;
      iv_in  = iv_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;
      if (ctrl.load) begin
         r_in   = '0;
         s_in   = '0;
         key_in = key_bits;
         iv_in  = iv_bits;
         acc_in = '0;
         pos_in = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         if (ctrl.step) begin
            r_in = r_next(r_ff, in_bit ^ (ctrl.mixing & s_ff[50]), ctrl_r);
            s_in = s_next(s_ff, in_bit, ctrl_s);
         end
         // advance the bit source that was just consumed
         if (ctrl.step && ctrl.in_sel == IN_IV)  iv_in  = {iv_ff[HALF_W-2:0], 1'b0};
         if (ctrl.step && ctrl.in_sel == IN_KEY) key_in = {key_ff[HALF_W-2:0], 1'b0};
         if (ctrl.capture) begin
            acc_in = acc_ff | (pos_ff & {WORD_W{z_bit}});
            pos_in = {1'b0, pos_ff[WORD_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      s_ff   <= s_in;
      key_ff <= key_in;
      iv_ff  <= iv_in;
      acc_ff <= acc_in;
      pos_ff <= pos_in;
   end

   assign word = acc_ff;

endmodule

[design/mk2_seq.sv]
// ----------------------------------------------------------------------------
// mk2_seq
// Phase sequencer: IV load, key load, preclock, keystream capture, hand-off.
// ----------------------------------------------------------------------------
module mk2_seq import mk2_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   input  logic [IVLEN_W-1:0] ivn,
   input  logic [NBITS_W-1:0] nb,
   output logic               idle,
   output mk2_ctrl_type       ctrl
);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [CNT_W-1:0]  nb_ext;

   assign nb_ext = {1'b0, nb};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 7'd1;
      ctrl     = '{load: 1'b0, step: 1'b0, in_sel: IN_ZERO, mixing: 1'b1,
                   capture: 1'b0, finish: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = (ivn == '0) ? ST_KEY : ST_IV;
            end
         end
         ST_IV: begin
            ctrl.step   = 1'b1;
            ctrl.in_sel = IN_IV;
            if (cnt_ff == ivn - 7'd1) begin
               state_in = ST_KEY;
               cnt_in   = '0;
            end
         end
         ST_KEY: begin
            ctrl.step   = 1'b1;
            ctrl.in_sel = IN_KEY;
            if (cnt_ff == KEY_LAST) begin
               state_in = ST_PRE;
               cnt_in   = '0;
            end
         end
         ST_PRE: begin
            ctrl.step = 1'b1;
            if (cnt_ff == PRE_LAST) begin
               state_in = (nb == '0) ? ST_FINISH : ST_GEN;
               cnt_in   = '0;
            end
         end
         ST_GEN: begin
            // read the output bit, then clock unless it was the last one
            ctrl.capture = 1'b1;
            ctrl.mixing  = 1'b0;
            if (cnt_ff == nb_ext - 7'd1) begin
               state_in = ST_FINISH;
               cnt_in   = '0;
            end else begin
               ctrl.step = 1'b1;
            end
         end
         ST_FINISH: begin
            cnt_in = '0;
            if (out_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

`ifndef NO_ASSERTIONS
   a_iv_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IV |-> cnt_ff < ivn)
      else $error("IV phase ran past the IV length");
   a_gen_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GEN |-> cnt_ff < nb_ext)
      else $error("keystream phase ran past the bit count");
   a_last_no_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN && cnt_ff == nb_ext - 7'd1) |-> !ctrl.step)
      else $error("generator clocked after the last keystream bit");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after hand-off");
`endif

endmodule

[design/mickey2_keystream_word.sv]
// ----------------------------------------------------------------------------
// mickey2_keystream_word
// MICKEY 2.0 keystream word generator: key/IV in, first keystream bits out.
// ----------------------------------------------------------------------------
// Sequence: an accepted request is loaded, the IV bits, the key bits and the
//   preclock steps are clocked in, then output_bit_count bits are captured.
// One transaction at a time: the single R/S update unit performs one clock
//   per cycle while stepping, and the word is handed to rsp_tvalid.
// Reset: synchronous, active high; clears the sequencer, the result valid and
//   the configuration to iv_length = 80 and output_bit_count = 32.
module mickey2_keystream_word import mk2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request: key_upper[63:0], key_lower[79:64], iv_upper[143:80],
   //          iv_lower[159:144]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [159:0]          req_tdata,
   // response: keystream_word[31:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata,
   // register writes: index 0 = iv_length, 1 = output_bit_count
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [IVLEN_W-1:0] ivlen_ff, ivlen_in;
   logic [NBITS_W-1:0] nbits_ff, nbits_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff,  rsp_data_in;

   logic [IVLEN_W-1:0] ivn;
   logic [NBITS_W-1:0] nb;
   logic               idle;
   logic               start;
   logic               out_free;
   logic [WORD_W-1:0]  word;
   logic [HALF_W-1:0]  key_bits;
   logic [HALF_W-1:0]  iv_bits;
   mk2_ctrl_type       ctrl;

   // Configuration: always ready, unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      ivlen_in = ivlen_ff;
      nbits_in = nbits_ff;
      if (csr_valid) begin
         if (csr_index == CSR_IV_LENGTH) ivlen_in = csr_data;
         if (csr_index == CSR_OUT_BITS)  nbits_in = csr_data[NBITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ivlen_ff <= IV_BITS_MAX;
         nbits_ff <= WORD_BITS_MAX;
      end else begin
         ivlen_ff <= ivlen_in;
         nbits_ff <= nbits_in;
      end
   end

   // Saturate oversized settings to the cipher limits.
   assign ivn = (ivlen_ff > IV_BITS_MAX)   ? IV_BITS_MAX   : ivlen_ff;
   assign nb  = (nbits_ff > WORD_BITS_MAX) ? WORD_BITS_MAX : nbits_ff;

   // Request side: take a new transaction whenever the sequencer is idle;
   // a finished word may still be waiting in the response register.
   assign req_tready = idle;
   assign start      = req_tvalid & idle;

   // Key and IV loaded MSB first: upper 64 bits, then the 16 lower bits.
   assign key_bits = {req_tdata[63:0],    req_tdata[79:64]};
   assign iv_bits  = {req_tdata[143:80],  req_tdata[159:144]};

   mk2_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ivn      (ivn),
      .nb       (nb),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   mk2_core u_core (
      .clock    (clock),
      .ctrl     (ctrl),
      .key_bits (key_bits),
      .iv_bits  (iv_bits),
      .word     (word)
   );

   // Response register: hold the word until the transaction completes.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !ctrl.finish)
      else $error("pending response overwritten");
   a_busy_no_load: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> idle)
      else $error("new transaction loaded while busy");
   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid_ff)
      else $error("finished word not presented");
`endif

endmodule

[test/tb_mickey2_keystream_word.sv]
// ----------------------------------------------------------------------------
// tb_mickey2_keystream_word
// Self-checking bench for the MICKEY 2.0 keystream word generator. A bit-level
// model of the R/S register pair predicts each keystream word from the key,
// the IV and the current register settings; every response is compared in
// order. Requests arrive in bursts, responses meet a stalling receiver, and
// the settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_mickey2_keystream_word;
   timeunit 1ns;
   timeprecision 1ps;

   import mk2_pkg::*;

   // Register indexes the block does not decode; writes to them must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // Feedback taps of R, the two mixing masks of S, its feedback words for
   // control 0 and 1, and the bits of S that take the mixing term.
   localparam logic [99:0] R_FEED      = 100'h3_df87818f_b5546660_1279327b;
   localparam logic [99:0] S_FLIP_A    = 100'h6_057ebfea_7942a809_6aa97a30;
   localparam logic [99:0] S_FLIP_B    = 100'h1_91c23dd7_e3a21d63_dd629e9a;
   localparam logic [99:0] S_FEED_LO   = 100'h1_9cec5802_af4a9381_9ffa7faf;
   localparam logic [99:0] S_FEED_HI   = 100'h8_40fbc52b_4911b063_4c8cb877;
   localparam logic [99:0] S_MIX_KEEP  = 100'h7_ffffffff_ffffffff_fffffffe;

   // The limit covers the work, the widest sender gap and the longest receiver
   // stall for each of the ~1800 requests, so stop only well beyond that.
   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 125;

   // -------------------------------------------------------------------------
   // Predictor and in-order store of expected keystream words
   // -------------------------------------------------------------------------
   class keystream_scoreboard;
      logic [6:0]  iv_len_cfg;
      logic [5:0]  bit_cnt_cfg;
      logic [99:0] r_q;
      logic [99:0] s_q;
      logic [31:0] expected_words[$];
      int          errors;

      function new();
         iv_len_cfg  = 7'd80;
         bit_cnt_cfg = 6'd32;
         errors      = 0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_IV_LENGTH) iv_len_cfg = data[6:0];
         else if (idx == CSR_OUT_BITS) bit_cnt_cfg = data[5:0];
      endfunction

      // One step of the generator; both control bits come from the old state.
      function void clock_pair(logic in_bit, logic mixing);
         logic        ctl_r;
         logic        ctl_s;
         logic [99:0] r_new;
         logic [99:0] s_new;
         logic [99:0] mix;
         ctl_r = s_q[34] ^ r_q[67];
         ctl_s = s_q[67] ^ r_q[33];
         r_new = r_q << 1;
         if (ctl_r) r_new = r_new ^ r_q;
         if (r_q[99] ^ in_bit ^ (mixing & s_q[50])) r_new = r_new ^ R_FEED;
         mix   = (s_q ^ S_FLIP_A) & ((s_q >> 1) ^ S_FLIP_B) & S_MIX_KEEP;
         s_new = (s_q << 1) ^ mix;
         if (s_q[99] ^ in_bit) s_new = s_new ^ (ctl_s ? S_FEED_HI : S_FEED_LO);
         r_q = r_new;
         s_q = s_new;
      endfunction

      // Key and IV bit 0 is bit 79 of the 80-bit value.
      function void note_request(logic [79:0] key, logic [79:0] iv);
         int          iv_bits;
         int          out_bits;
         int          j;
         logic [31:0] word;
         iv_bits  = (iv_len_cfg > 7'd80) ? 80 : int'(iv_len_cfg);
         out_bits = (bit_cnt_cfg > 6'd32) ? 32 : int'(bit_cnt_cfg);
         r_q  = '0;
         s_q  = '0;
         word = '0;
         for (j = 0; j < iv_bits; j++) clock_pair(iv[79-j], 1'b1);
         for (j = 0; j < 80; j++) clock_pair(key[79-j], 1'b1);
         for (j = 0; j < 100; j++) clock_pair(1'b0, 1'b1);
         for (j = 0; j < out_bits; j++) begin
            word[31-j] = r_q[0] ^ s_q[0];
            if (j + 1 < out_bits) clock_pair(1'b0, 1'b0);
         end
         expected_words.push_back(word);
      endfunction

      function void check_word(logic [31:0] actual);
         logic [31:0] want;
         if (expected_words.size() == 0) begin
            $error("keystream_word: unexpected response %h", actual);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (actual !== want) begin
               $error("keystream_word mismatch: expected %h, actual %h", want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [159:0]          req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [WORD_W-1:0]     rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   keystream_scoreboard sb = new();

   int cycle_count   = 0;
   int items_sent    = 0;
   int words_checked = 0;
   int settings_used = 1;
   int burst_left    = 0;

   always #5 clock = ~clock;

   mickey2_keystream_word dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Give up on a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: switch between always-ready, coin-flip and long-stall modes so
   // that backpressure lands on every phase of the response handshake.
   // -------------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(50, 2000);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 1) != 0);
         end
         default: begin
            if (stall_left != 0) begin
               rsp_tready <= 1'b0;
               stall_left <= stall_left - 1;
            end else begin
               rsp_tready <= 1'b1;
               stall_left <= $urandom_range(0, 40);
            end
         end
      endcase
   end

   // Check every accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata);
         words_checked++;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Random 80-bit key or IV, with some all-zero, all-one and one-hot values.
   function automatic logic [79:0] pick_block();
      logic [79:0] v;
      v = {$urandom, $urandom, 16'($urandom)};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = 80'd1 << $urandom_range(0, 79);
         3: v = ~(80'd1 << $urandom_range(0, 79));
         default: ;
      endcase
      return v;
   endfunction

   // Send one key/IV transaction. Open a random gap between bursts; keep
   // tvalid high across back-to-back transactions of a burst.
   task automatic send_request(input logic [79:0] key, input logic [79:0] iv);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 320);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      // iv_lower, iv_upper, key_lower, key_upper from the top bits down
      req_tdata  <= {iv[15:0], iv[79:16], key[15:0], key[79:16]};
      do @(posedge clock); while (!req_tready);
      sb.note_request(key, iv);
      items_sent++;
   endtask

   // Hold off requests until every expected word has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Raise csr_valid and wait for the transaction; the caller drops csr_valid
   // after its last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.apply_reg(idx, data);
   endtask

   // Drain, then write both registers in random order, sometimes preceded by
   // a write to an unused index.
   task automatic change_setting(input logic [CSR_DATA_W-1:0] iv_data,
                                 input logic [CSR_DATA_W-1:0] cnt_data);
      wait_idle();
      if ($urandom_range(0, 2) == 0)
         write_reg(($urandom_range(0, 1) != 0) ? CSR_SPARE_B : CSR_SPARE_A,
                   7'($urandom));
      if ($urandom_range(0, 1) != 0) begin
         write_reg(CSR_IV_LENGTH, iv_data);
         write_reg(CSR_OUT_BITS, cnt_data);
      end else begin
         write_reg(CSR_OUT_BITS, cnt_data);
         write_reg(CSR_IV_LENGTH, iv_data);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int                    dir_iv[6];
      int                    dir_cnt[6];
      int                    p;
      int                    n;
      logic [CSR_DATA_W-1:0] iv_data;
      logic [CSR_DATA_W-1:0] cnt_data;

      // Settings that hit no IV bits, one output bit, saturation of both
      // registers, a zero bit count and values just inside the limits.
      dir_iv  = '{0, 127, 81, 80, 1, 79};
      dir_cnt = '{1, 63, 33, 0, 32, 31};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: extremes of the key and IV fields.
      send_request('0, '0);
      send_request('1, '1);
      send_request('1, '0);
      send_request('0, '1);
      send_request({64'haaaaaaaa_aaaaaaaa, 16'h5555}, {64'h55555555_55555555, 16'haaaa});
      send_request(80'd1 << 79, 80'd1);
      send_request(80'd1 << 16, 80'd1 << 15);
      send_request(80'd1 << 15, 80'd1 << 79);

      // Writes to unused indexes must leave both settings alone.
      wait_idle();
      write_reg(CSR_SPARE_A, 7'h7f);
      write_reg(CSR_SPARE_B, 7'h00);
      csr_valid <= 1'b0;
      send_request(pick_block(), pick_block());
      send_request(pick_block(), pick_block());

      for (p = 0; p < 6; p++) begin
         change_setting(7'(dir_iv[p]), 7'(dir_cnt[p]));
         send_request('1, '0);
         send_request(pick_block(), pick_block());
      end

      // Random phases: random settings, often at the edges of their range.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 4))
            0: iv_data = 7'd0;
            1: iv_data = 7'd80;
            2: iv_data = 7'd127;
            default: iv_data = 7'($urandom_range(0, 127));
         endcase
         case ($urandom_range(0, 5))
            0: cnt_data = 7'd0;
            1: cnt_data = 7'd1;
            2: cnt_data = 7'd32;
            3: cnt_data = 7'd63;
            default: cnt_data = 7'($urandom_range(0, 127));
         endcase
         change_setting(iv_data, cnt_data);
         for (n = 0; n < PHASE_ITEMS; n++) send_request(pick_block(), pick_block());
      end

      // Drain, then watch a while longer for stray responses.
      wait_idle();
      repeat (400) @(posedge clock);

      $display("Sent %0d key/IV requests under %0d register settings, %0d words checked",
               items_sent, settings_used, words_checked);
      $display("Settings covered zero and saturated IV lengths and bit counts");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
